// ===== sv/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// Settle centre sampler package
// Shared constants: item kinds, register indexes, field widths, reset values.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int TIME_W = 63;
    localparam int CFG_W  = 24;
    localparam int CFG_AW = 3;
    localparam int CNT_W  = 4;

    // item kinds carried on tuser
    localparam logic FUNC_BEGIN  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_SETTLE_DELAY   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_CAPTURE_WINDOW = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_MAX_AGE        = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SPREAD_LIMIT   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_LEVEL_LIMIT    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_NEEDED_COUNT   = 3'd5;

    localparam logic [23:0]      RST_SETTLE_DELAY   = 24'd1000000;
    localparam logic [23:0]      RST_CAPTURE_WINDOW = 24'd3500000;
    localparam logic [23:0]      RST_MAX_AGE        = 24'd300000;
    localparam logic [15:0]      RST_SPREAD_LIMIT   = 16'd154;
    localparam logic [15:0]      RST_LEVEL_LIMIT    = 16'd1024;
    localparam logic [CNT_W-1:0] RST_NEEDED_COUNT   = 4'd5;

    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

endpackage

// ===== sv/settle_center_sampler.sv =====
// ----------------------------------------------------------------------------
// Settle centre sampler
// Arms a yaw capture on a begin item, gathers settled camera readings and
// reports the middle of the settled yaw range.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while the master side is not stalling.
// A transfer lands in the input register; the capture state and the result
// register are then updated together from it, once the result register is
// free, and the result can be taken from there. The rate is set by the state
// update: each item reads the range, count and time marks that the previous
// item left, through a single combinational compare-and-select path. The
// result register frees itself whenever the master side takes its transfer,
// so both sides may stall independently.
module settle_center_sampler #(
    parameter int ANGLE_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [scs_pkg::CFG_AW-1:0]             i_cfg_addr,
    input  logic [scs_pkg::CFG_W-1:0]              i_cfg_wdata,
    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, lsb up: time_us, quiet, cam_valid, cam_time_us, cam_yaw, cam_pitch
    input  logic [((128+2*ANGLE_BITS+7)/8)*8-1:0]  s_axis_tdata,
    // tuser: func
    input  logic                                   s_axis_tuser,
    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata, lsb up: center_found, center_yaw, still_pending
    output logic [((ANGLE_BITS+2+7)/8)*8-1:0]      m_axis_tdata
);
    import scs_pkg::*;

    localparam int IN_W      = ((128 + 2*ANGLE_BITS + 7) / 8) * 8;
    localparam int QUIET_BIT = TIME_W;
    localparam int CVAL_BIT  = TIME_W + 1;
    localparam int CTIME_LSB = TIME_W + 2;
    localparam int YAW_LSB   = 2*TIME_W + 2;
    localparam int PITCH_LSB = YAW_LSB + ANGLE_BITS;

    // configuration
    logic [23:0]      r_settle_delay, r_capture_window, r_max_age;
    logic [15:0]      r_spread_limit, r_level_limit;
    logic [CNT_W-1:0] r_needed_count;

    // input register
    logic             r_in_valid;
    logic [IN_W-1:0]  r_in_data;
    logic             r_in_func;

    // capture state
    logic                         r_armed, n_armed;
    logic [TIME_W:0]              r_due, n_due, r_expire, n_expire;
    logic [TIME_W-1:0]            r_last, n_last;
    logic signed [ANGLE_BITS-1:0] r_low, n_low, r_high, n_high;
    logic [CNT_W-1:0]             r_cnt, n_cnt;

    // result register
    logic                         r_out_valid;
    logic                         r_out_found, n_found;
    logic signed [ANGLE_BITS-1:0] r_out_yaw, n_yaw;
    logic                         r_out_pending;

    logic advance;

    // unpacked fields of the held item
    logic [TIME_W-1:0]            now, ctime, age;
    logic                         quiet, cvalid;
    logic signed [ANGLE_BITS-1:0] yaw, pitch, min_lo, max_hi;
    logic [ANGLE_BITS-1:0]        apitch;
    logic signed [ANGLE_BITS:0]   spread, mid_sum;
    logic                         fresh, reject;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_delay   <= RST_SETTLE_DELAY;
            r_capture_window <= RST_CAPTURE_WINDOW;
            r_max_age        <= RST_MAX_AGE;
            r_spread_limit   <= RST_SPREAD_LIMIT;
            r_level_limit    <= RST_LEVEL_LIMIT;
            r_needed_count   <= RST_NEEDED_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SETTLE_DELAY:   r_settle_delay   <= i_cfg_wdata;
                CFG_CAPTURE_WINDOW: r_capture_window <= i_cfg_wdata;
                CFG_MAX_AGE:        r_max_age        <= i_cfg_wdata;
                CFG_SPREAD_LIMIT:   r_spread_limit   <= i_cfg_wdata[15:0];
                CFG_LEVEL_LIMIT:    r_level_limit    <= i_cfg_wdata[15:0];
                CFG_NEEDED_COUNT:   r_needed_count   <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        now    = r_in_data[TIME_W-1:0];
        quiet  = r_in_data[QUIET_BIT];
        cvalid = r_in_data[CVAL_BIT];
        ctime  = r_in_data[CTIME_LSB +: TIME_W];
        yaw    = r_in_data[YAW_LSB +: ANGLE_BITS];
        pitch  = r_in_data[PITCH_LSB +: ANGLE_BITS];
        // the most negative pitch comes out as its true magnitude when read unsigned
        apitch = pitch[ANGLE_BITS-1] ? ANGLE_BITS'(-pitch) : ANGLE_BITS'(pitch);
        age    = now - ctime;
        fresh  = (ctime != '0) && (now >= ctime)
                 && (age < {{(TIME_W-24){1'b0}}, r_max_age});
        reject = ({1'b0, now} < r_due) || !cvalid || !fresh
                 || (apitch > {{(ANGLE_BITS-16){1'b0}}, r_level_limit})
                 || (ctime <= r_last);
        min_lo  = (yaw < r_low)  ? yaw : r_low;
        max_hi  = (yaw > r_high) ? yaw : r_high;
        spread  = {max_hi[ANGLE_BITS-1], max_hi} - {min_lo[ANGLE_BITS-1], min_lo};

        n_armed  = r_armed;
        n_due    = r_due;
        n_expire = r_expire;
        n_last   = r_last;
        n_low    = r_low;
        n_high   = r_high;
        n_cnt    = r_cnt;
        n_found  = 1'b0;
        n_yaw    = '0;

        if (r_in_func == FUNC_BEGIN) begin
            n_armed  = 1'b1;
            n_due    = {1'b0, now} + {{(TIME_W-23){1'b0}}, r_settle_delay};
            n_expire = {1'b0, now} + {{(TIME_W-23){1'b0}}, r_capture_window};
            n_last   = '0;
            n_low    = '0;
            n_high   = '0;
            n_cnt    = '0;
        end else if (r_armed) begin
            if (!quiet || ({1'b0, now} >= r_expire)) begin
                n_armed = 1'b0;
            end else if (!reject) begin
                n_last = ctime;
                if (r_cnt == '0) begin
                    n_low  = yaw;
                    n_high = yaw;
                    n_cnt  = CNT_W'(1);
                end else if (spread > $signed({{(ANGLE_BITS-16){1'b0}}, 1'b0, r_spread_limit}))
                begin
                    // range too wide: restart the run from this reading
                    n_low  = yaw;
                    n_high = yaw;
                    n_cnt  = CNT_W'(1);
                end else begin
                    n_low  = min_lo;
                    n_high = max_hi;
                    if (r_cnt < CNT_MAX) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
                if (n_cnt >= r_needed_count) begin
                    n_found = 1'b1;
                    n_armed = 1'b0;
                end
            end
        end

        mid_sum = {n_low[ANGLE_BITS-1], n_low} + {n_high[ANGLE_BITS-1], n_high};
        if (n_found) begin
            n_yaw = mid_sum[ANGLE_BITS:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_armed     <= 1'b0;
            r_due       <= '0;
            r_expire    <= '0;
            r_last      <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_cnt       <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && advance) begin
                r_armed  <= n_armed;
                r_due    <= n_due;
                r_expire <= n_expire;
                r_last   <= n_last;
                r_low    <= n_low;
                r_high   <= n_high;
                r_cnt    <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
            r_in_func <= s_axis_tuser;
        end
        if (r_in_valid && advance) begin
            r_out_found   <= n_found;
            r_out_yaw     <= n_yaw;
            r_out_pending <= n_armed;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    always_comb begin
        m_axis_tdata                   = '0;
        m_axis_tdata[0]                = r_out_found;
        m_axis_tdata[1 +: ANGLE_BITS]  = r_out_yaw;
        m_axis_tdata[ANGLE_BITS+1]     = r_out_pending;
    end

    // a reported centre always closes the capture
    a_found_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> !r_out_pending)
        else $error("centre reported while capture still pending");

    a_begin_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in_func == FUNC_BEGIN) |=> (r_armed && r_cnt == '0))
        else $error("begin item did not arm a fresh capture");

    a_idle_no_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_in_func == FUNC_SAMPLE && !r_armed)
        |=> (!r_out_found && !r_out_pending && !r_armed))
        else $error("sample while disarmed changed the capture");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Settle centre sampler testbench
// Drives begin and camera sample transfers into the block, predicts every
// result from a local model of the capture state, and checks each output
// transfer field by field. A directed part covers the corner cases, then
// whole random captures run under several register settings and idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import scs_pkg::*;

    localparam int ANG_W       = 24;
    localparam int IN_W        = ((128+2*ANG_W+7)/8)*8;
    localparam int OUT_W       = ((ANG_W+2+7)/8)*8;
    localparam int CYCLE_LIMIT = 300000;

    // index outside the register map; a write there must change nothing
    localparam logic [CFG_AW-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [ANG_W-1:0] cam_pitch;
        logic signed [ANG_W-1:0] cam_yaw;
        logic [TIME_W-1:0]       cam_time_us;
        logic                    cam_valid;
        logic                    quiet;
        logic [TIME_W-1:0]       time_us;
    } reading_t;

    typedef struct packed {
        logic                    pending;
        logic signed [ANG_W-1:0] yaw;
        logic                    found;
    } centre_t;

    typedef struct packed {
        logic [23:0]      settle;
        logic [23:0]      window;
        logic [23:0]      max_age;
        logic [15:0]      spread;
        logic [15:0]      level;
        logic [CNT_W-1:0] needed;
    } settings_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;   // time_us, quiet, cam_valid, cam_time_us, cam_yaw, cam_pitch
    logic              s_axis_tuser = 1'b0; // func
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;        // center_found, center_yaw, still_pending

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int items_sent = 0;
    int cycle_count = 0;

    centre_t expected_centres[$];

    // local copy of the capture state and registers
    logic                    st_armed;
    logic [63:0]             st_due;
    logic [63:0]             st_expire;
    logic [TIME_W-1:0]       st_last_used;
    logic signed [ANG_W-1:0] st_yaw_lo;
    logic signed [ANG_W-1:0] st_yaw_hi;
    logic [CNT_W-1:0]        st_count;
    logic [23:0]             cfg_settle;
    logic [23:0]             cfg_window;
    logic [23:0]             cfg_max_age;
    logic [15:0]             cfg_spread;
    logic [15:0]             cfg_level;
    logic [CNT_W-1:0]        cfg_needed;

    settle_center_sampler #(
        .ANGLE_BITS(ANG_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic centre_t predict_centre(input logic func, input reading_t rd);
        centre_t     res;
        logic [63:0] now;
        int          yaw;
        int          pitch_mag;
        int          lo;
        int          hi;
        logic        fresh;
        res = '0;
        now = {1'b0, rd.time_us};
        yaw = rd.cam_yaw;
        pitch_mag = rd.cam_pitch;
        if (pitch_mag < 0)
            pitch_mag = -pitch_mag;
        fresh = (rd.cam_time_us != 0) && (rd.time_us >= rd.cam_time_us) &&
                ({1'b0, rd.time_us - rd.cam_time_us} < {40'b0, cfg_max_age});
        if (func == FUNC_BEGIN) begin
            st_armed     = 1'b1;
            st_due       = now + {40'b0, cfg_settle};
            st_expire    = now + {40'b0, cfg_window};
            st_last_used = '0;
            st_yaw_lo    = '0;
            st_yaw_hi    = '0;
            st_count     = '0;
        end else if (st_armed) begin
            if (!rd.quiet || now >= st_expire) begin
                st_armed = 1'b0;
            end else if (now >= st_due && rd.cam_valid && fresh &&
                         pitch_mag <= int'(cfg_level) && rd.cam_time_us > st_last_used) begin
                st_last_used = rd.cam_time_us;
                lo = st_yaw_lo;
                hi = st_yaw_hi;
                if (st_count == 0) begin
                    lo = yaw;
                    hi = yaw;
                    st_count = 1;
                end else begin
                    if (yaw < lo)
                        lo = yaw;
                    if (yaw > hi)
                        hi = yaw;
                    // range too wide: restart the run from this reading
                    if (hi - lo > int'(cfg_spread)) begin
                        lo = yaw;
                        hi = yaw;
                        st_count = 1;
                    end else if (st_count < CNT_MAX) begin
                        st_count = st_count + 1'b1;
                    end
                end
                st_yaw_lo = ANG_W'(lo);
                st_yaw_hi = ANG_W'(hi);
                if (st_count >= cfg_needed) begin
                    res.found = 1'b1;
                    res.yaw   = ANG_W'((lo + hi) >>> 1);
                    st_armed  = 1'b0;
                end
            end
        end
        res.pending = st_armed;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 100)
            $display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    // predictor update, register mirror and result check
    always @(posedge i_clk) begin
        reading_t rd;
        centre_t  got;
        centre_t  want;
        if (!i_rst_n) begin
            st_armed     = 1'b0;
            st_due       = '0;
            st_expire    = '0;
            st_last_used = '0;
            st_yaw_lo    = '0;
            st_yaw_hi    = '0;
            st_count     = '0;
            cfg_settle   = RST_SETTLE_DELAY;
            cfg_window   = RST_CAPTURE_WINDOW;
            cfg_max_age  = RST_MAX_AGE;
            cfg_spread   = RST_SPREAD_LIMIT;
            cfg_level    = RST_LEVEL_LIMIT;
            cfg_needed   = RST_NEEDED_COUNT;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SETTLE_DELAY:   cfg_settle  = i_cfg_wdata[23:0];
                    CFG_CAPTURE_WINDOW: cfg_window  = i_cfg_wdata[23:0];
                    CFG_MAX_AGE:        cfg_max_age = i_cfg_wdata[23:0];
                    CFG_SPREAD_LIMIT:   cfg_spread  = i_cfg_wdata[15:0];
                    CFG_LEVEL_LIMIT:    cfg_level   = i_cfg_wdata[15:0];
                    CFG_NEEDED_COUNT:   cfg_needed  = i_cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            // check before queueing so a stray result cannot match a fresh item
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[ANG_W+1:0];
                if (expected_centres.size() == 0) begin
                    report_mismatch("transfer with nothing outstanding", 32'(got), '0);
                end else begin
                    want = expected_centres.pop_front();
                    if (got.found !== want.found)
                        report_mismatch("center_found", 32'(got.found), 32'(want.found));
                    if (got.yaw !== want.yaw)
                        report_mismatch("center_yaw", 32'(got.yaw), 32'(want.yaw));
                    if (got.pending !== want.pending)
                        report_mismatch("still_pending", 32'(got.pending), 32'(want.pending));
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rd = s_axis_tdata;
                expected_centres.push_back(predict_centre(s_axis_tuser, rd));
            end
        end
    end

    task automatic send_item(input logic func, input reading_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(r);
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic reading_t random_reading();
        reading_t r;
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return r;
    endfunction

    task automatic begin_capture(input logic [TIME_W-1:0] t);
        reading_t r;
        r = random_reading();
        r.time_us = t;
        send_item(FUNC_BEGIN, r);
    endtask

    task automatic offer(input logic [TIME_W-1:0] now, input logic quiet, input logic valid,
                         input logic [TIME_W-1:0] ctime, input int yaw, input int pitch);
        reading_t r;
        r.time_us     = now;
        r.quiet       = quiet;
        r.cam_valid   = valid;
        r.cam_time_us = ctime;
        r.cam_yaw     = ANG_W'(yaw);
        r.cam_pitch   = ANG_W'(pitch);
        send_item(FUNC_SAMPLE, r);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_centres.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(input settings_t s);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_SETTLE_DELAY;
        i_cfg_wdata <= s.settle;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_CAPTURE_WINDOW;
        i_cfg_wdata <= s.window;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_MAX_AGE;
        i_cfg_wdata <= s.max_age;
        @(posedge i_clk);
        // junk in the unused upper bits must be dropped
        i_cfg_addr  <= CFG_SPREAD_LIMIT;
        i_cfg_wdata <= {8'($urandom), s.spread};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_LEVEL_LIMIT;
        i_cfg_wdata <= {8'($urandom), s.level};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_NEEDED_COUNT;
        i_cfg_wdata <= {20'($urandom), s.needed};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_UNUSED;
        i_cfg_wdata <= 24'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
    endtask

    // one begin followed by a run of mostly plausible readings
    task automatic run_capture();
        logic [63:0] t0;
        logic [63:0] now;
        logic [63:0] ctime;
        logic [63:0] prev_ctime;
        int k, stride, age, lim, anchor, half, yaw, pitch, lvl, roll;
        reading_t r;
        k = int'(cfg_needed) + $urandom_range(0, 6);
        if ($urandom_range(99) < 70)
            t0 = 64'($urandom_range(0, 32'h3FFF_FFFF));
        else
            t0 = {1'b0, 31'($urandom), $urandom};
        if (t0[62:32] == '1)
            t0 = t0 - 64'h1_0000_0000;
        begin_capture(t0[TIME_W-1:0]);
        stride = int'(cfg_window) / (k + 1) + 1;
        now = t0 + 64'($urandom_range(0, int'(cfg_settle) + int'(cfg_settle) / 4 + 1));
        prev_ctime = '0;
        anchor = $urandom;
        half = int'(cfg_spread) * 5 / 8 + 1;
        lim = int'(cfg_max_age);
        lvl = int'(cfg_level);
        for (int j = 0; j < k; j++) begin
            now = now + 64'($urandom_range(0, ($urandom_range(99) < 15) ? stride * 4 : stride));
            roll = $urandom_range(99);
            if (roll < 80)
                age = $urandom_range(0, (lim > 0) ? lim - 1 : 0);
            else if (roll < 92)
                age = $urandom_range(lim, 2 * lim + 1);
            else
                age = $urandom_range(0, 3);
            ctime = (64'(age) > now) ? 64'd0 : now - 64'(age);
            roll = $urandom_range(99);
            if (roll < 4)
                ctime = '0;
            else if (roll < 8)
                ctime = now + 64'($urandom_range(1, 1000));
            else if (roll < 13)
                ctime = prev_ctime;
            prev_ctime = ctime;
            if ($urandom_range(99) < 8)
                yaw = $urandom;
            else
                yaw = anchor + int'($urandom_range(0, 2 * half)) - half;
            if ($urandom_range(99) < 10)
                pitch = $urandom;
            else
                pitch = int'($urandom_range(0, 2 * lvl)) - lvl;
            r.time_us     = now[TIME_W-1:0];
            r.quiet       = ($urandom_range(99) < 97);
            r.cam_valid   = ($urandom_range(99) < 95);
            r.cam_time_us = ctime[TIME_W-1:0];
            r.cam_yaw     = ANG_W'(yaw);
            r.cam_pitch   = ANG_W'(pitch);
            send_item(FUNC_SAMPLE, r);
        end
        items_sent += k + 1;
    endtask

    function automatic settings_t random_settings();
        settings_t s;
        s.settle  = $urandom_range(0, 20000);
        s.window  = s.settle + $urandom_range(1, 200000);
        s.max_age = $urandom_range(1, 5000);
        s.spread  = $urandom_range(0, 400);
        s.level   = $urandom_range(0, 2000);
        s.needed  = $urandom_range(1, 8);
        return s;
    endfunction

    // runs on the register values left by reset
    task automatic test_reset_config();
        offer(100, 1, 1, 50, 0, 0);                 // sample with nothing armed
        begin_capture(1000);
        offer(500000, 1, 1, 400000, 0, 0);          // still settling
        offer(1100000, 1, 0, 1050000, 0, 0);        // camera invalid
        offer(1100000, 1, 1, 700000, 0, 0);         // reading too old
        offer(1100000, 1, 1, 0, 0, 0);              // zero timestamp
        offer(1100000, 1, 1, 1200000, 0, 0);        // timestamp ahead of now
        offer(1100000, 1, 1, 1050000, 0, -1025);    // tilted past the level limit
        offer(1001000, 1, 1, 1000500, 100, 1024);   // exactly at due time, level edge
        offer(1110000, 1, 1, 1000500, 100, 0);      // timestamp not newer
        offer(1120000, 1, 1, 1060000, -54, -1024);  // spread exactly at the limit
        offer(1130000, 1, 1, 1070000, 101, 0);      // one past: run restarts
        offer(1140000, 1, 1, 1080000, -53, 0);
        offer(1150000, 1, 1, 1090000, 0, 0);
        offer(1160000, 1, 1, 1100000, 50, 0);
        offer(1170000, 1, 1, 1110000, 60, 0);       // fifth in the run: centre
        begin_capture(2000000);
        offer(2500000, 0, 1, 2400000, 0, 0);        // user moved
        begin_capture(0);
        offer(3499999, 1, 1, 3400000, 5, 0);        // last microsecond before expiry
        offer(3500000, 1, 1, 3400001, 5, 0);        // expired
        begin_capture('1);
        offer('1, 1, 1, {{(TIME_W-1){1'b1}}, 1'b0}, 0, 0);  // due time beyond 63 bits
    endtask

    task automatic test_limits();
        settings_t s;
        s = '{settle: 24'd0, window: '1, max_age: '1, spread: '1, level: '1, needed: '0};
        apply_settings(s);
        begin_capture(10);
        offer(20, 1, 1, 15, -3, 65535);             // zero count acts as one
        begin_capture(10);
        offer(20, 1, 1, 15, 0, -8388608);
        offer(21, 1, 1, 16, 0, 8388607);
        offer(22, 1, 1, 17, 7, -65535);
        s.needed = 2;
        apply_settings(s);
        begin_capture(100);
        offer(200, 1, 1, 101, -8388608, 0);
        offer(201, 1, 1, 102, -8388607, 0);         // odd negative sum rounds down
        begin_capture(100);
        offer(300, 1, 1, 250, 8388607, 0);
        offer(301, 1, 1, 251, 8388606, 0);
        s.max_age = '0;
        apply_settings(s);
        begin_capture(100);
        offer(200, 1, 1, 200, 0, 0);                // no reading is fresh
    endtask

    task automatic test_random_phases();
        settings_t plan[8];
        int        budget;
        plan[0] = '{settle: RST_SETTLE_DELAY, window: RST_CAPTURE_WINDOW,
                    max_age: RST_MAX_AGE, spread: RST_SPREAD_LIMIT,
                    level: RST_LEVEL_LIMIT, needed: RST_NEEDED_COUNT};
        plan[1] = '{settle: 24'd0, window: '1, max_age: '1, spread: '1, level: '1,
                    needed: CNT_MAX};
        plan[2] = '0;
        plan[3] = '{settle: '1, window: '1, max_age: '1, spread: '1, level: '1,
                    needed: CNT_MAX};
        for (int p = 4; p < 8; p++)
            plan[p] = random_settings();
        for (int p = 0; p < 8; p++) begin
            apply_settings(plan[p]);
            set_idling(p % 4);
            // shallow settings, where readings never count, get a short run
            budget = (p == 2 || p == 3) ? 80 : 250;
            items_sent = 0;
            while (items_sent < budget) begin
                if ($urandom_range(99) < 10) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(1'($urandom), random_reading());
                        items_sent++;
                    end
                end else begin
                    run_capture();
                end
            end
        end
        set_idling(0);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config();
        test_limits();
        test_random_phases();
        wait_drained();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
